FILE: design/generational_handle_allocator_defines.svh
// assertion macros shared by the checker of the handle allocator
// no dependencies; expects clk and rst in the scope of use
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define GHA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("handle allocator check failed");

// next-cycle implication
`define GHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("handle allocator check failed");

`endif

FILE: design/gha_pkg.sv
// shared types, codes and helpers of the handle allocator
// no dependencies
package gha_pkg;

  // action codes
  localparam logic [2:0] ACT_CREATE  = 3'd0;
  localparam logic [2:0] ACT_DESTROY = 3'd1;
  localparam logic [2:0] ACT_QUERY   = 3'd2;
  localparam logic [2:0] ACT_ADD     = 3'd3;
  localparam logic [2:0] ACT_REMOVE  = 3'd4;
  localparam logic [2:0] ACT_CLEAR   = 3'd5;

  // component kinds
  localparam logic [1:0] COMP_MESH   = 2'd0;
  localparam logic [1:0] COMP_LIGHT  = 2'd1;
  localparam logic [1:0] COMP_CAMERA = 2'd2;

  // pending update kinds
  localparam logic [1:0] PEND_NONE   = 2'd0;
  localparam logic [1:0] PEND_TOPO   = 2'd1;
  localparam logic [1:0] PEND_LIGHT  = 2'd2;
  localparam logic [1:0] PEND_CAMERA = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  function automatic logic [1:0] merge_kind(input logic [1:0] cur, input logic [1:0] k);
    logic [1:0] res;
    res = cur;
    if (k != PEND_NONE) begin
      if (cur == PEND_NONE) begin
        res = k;
      end else if (cur != k) begin
        res = PEND_TOPO;
      end
    end
    return res;
  endfunction

endpackage

FILE: design/gha_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/gha_ctrl.sv
// two-state sequencer of the handle allocator: accept, then execute
// depends on gha_pkg
module gha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output gha_pkg::cmd_t cmd
);

  gha_pkg::state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      gha_pkg::ST_IDLE: begin
        if (start) begin
          state_next = gha_pkg::ST_EXEC;
        end
      end
      gha_pkg::ST_EXEC: begin
        state_next = gha_pkg::ST_IDLE;
      end
      default: begin
        state_next = gha_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gha_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  assign busy     = (state == gha_pkg::ST_EXEC);
  assign cmd.load = (state == gha_pkg::ST_IDLE) && start;
  assign cmd.exec = (state == gha_pkg::ST_EXEC);

endmodule

FILE: design/gha_dp.sv
// datapath: slot table, free stack, counters and result registers
// depends on gha_pkg and gha_ram
module gha_dp #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  gha_pkg::cmd_t cmd,
  input  logic [2:0]    action,
  input  logic [7:0]    handle_index,
  input  logic [31:0]   handle_generation,
  input  logic [1:0]    component_kind,
  output logic          ok,
  output logic [7:0]    result_index,
  output logic [31:0]   result_generation,
  output logic          has_mesh,
  output logic          has_light,
  output logic          has_camera,
  output logic [1:0]    pending_update,
  output logic [8:0]    live_count
);

  localparam int IW = $clog2(SLOTS);
  localparam int HW = $clog2(SLOTS + 1);
  localparam int TW = GEN_BITS + 4;   // live, three flags, generation
  localparam int SW = IW + GEN_BITS;  // slot index, generation

  // captured request
  logic [2:0]  act_q;
  logic [7:0]  idx_q;
  logic [31:0] gen_q;
  logic [1:0]  kind_q;

  // control state
  logic [HW-1:0] free_top, free_top_next;
  logic [HW-1:0] high_water, high_water_next;
  logic [HW-1:0] live_total, live_total_next;
  logic [1:0]    pending, pending_next;

  // result values
  logic          ok_next;
  logic [7:0]    ridx_next;
  logic [31:0]   rgen_next;
  logic [2:0]    comps, comps_next;

  // memories
  logic          tbl_we;
  logic [IW-1:0] tbl_waddr;
  logic [TW-1:0] tbl_wdata, tbl_rdata;
  logic          stk_we;
  logic [IW-1:0] stk_waddr;
  logic [SW-1:0] stk_wdata, stk_rdata;

  // execute helpers
  logic                rd_live;
  logic [2:0]          rd_comps;
  logic [GEN_BITS-1:0] rd_gen;
  logic                valid;
  logic [IW-1:0]       slot_addr;
  logic [IW-1:0]       pop_slot;
  logic [GEN_BITS-1:0] pop_gen;
  logic [GEN_BITS-1:0] gen_bump;
  logic [2:0]          kbit;
  logic [1:0]          kmerge;
  logic [2:0]          new_comps;

  gha_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (IW'(handle_index)),
    .rdata (tbl_rdata)
  );

  gha_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_stk (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (IW'(free_top - HW'(1))),
    .rdata (stk_rdata)
  );

  assign rd_live   = tbl_rdata[TW-1];
  assign rd_comps  = tbl_rdata[TW-2 -: 3];
  assign rd_gen    = tbl_rdata[GEN_BITS-1:0];
  assign slot_addr = IW'(idx_q);
  assign pop_slot  = stk_rdata[SW-1:GEN_BITS];
  assign pop_gen   = stk_rdata[GEN_BITS-1:0];
  assign gen_bump  = rd_gen + GEN_BITS'(1);
  assign valid     = (32'(idx_q) < 32'(high_water)) && rd_live && (gen_q == 32'(rd_gen));

  always_comb begin
    kbit   = 3'b000;
    kmerge = gha_pkg::PEND_NONE;
    case (kind_q)
      gha_pkg::COMP_MESH: begin
        kbit   = 3'b001;
        kmerge = gha_pkg::PEND_TOPO;
      end
      gha_pkg::COMP_LIGHT: begin
        kbit   = 3'b010;
        kmerge = gha_pkg::PEND_LIGHT;
      end
      gha_pkg::COMP_CAMERA: begin
        kbit   = 3'b100;
        kmerge = gha_pkg::PEND_CAMERA;
      end
      default: begin
        kbit   = 3'b000;
        kmerge = gha_pkg::PEND_NONE;
      end
    endcase
  end

  always_comb begin
    tbl_we          = 1'b0;
    tbl_waddr       = slot_addr;
    tbl_wdata       = '0;
    stk_we          = 1'b0;
    stk_waddr       = IW'(free_top);
    stk_wdata       = {slot_addr, gen_bump};
    free_top_next   = free_top;
    high_water_next = high_water;
    live_total_next = live_total;
    pending_next    = pending;
    ok_next         = 1'b0;
    ridx_next       = '0;
    rgen_next       = '0;
    comps_next      = '0;
    new_comps       = rd_comps;
    case (act_q)
      gha_pkg::ACT_CREATE: begin
        if (free_top != '0) begin
          // reuse the most recently freed slot
          free_top_next   = free_top - HW'(1);
          tbl_we          = 1'b1;
          tbl_waddr       = pop_slot;
          tbl_wdata       = {1'b1, 3'b000, pop_gen};
          live_total_next = live_total + HW'(1);
          pending_next    = gha_pkg::merge_kind(pending, gha_pkg::PEND_TOPO);
          ok_next         = 1'b1;
          ridx_next       = 8'(pop_slot);
          rgen_next       = 32'(pop_gen);
        end else if (high_water < HW'(SLOTS)) begin
          // fresh slot, generation starts at zero
          high_water_next = high_water + HW'(1);
          tbl_we          = 1'b1;
          tbl_waddr       = IW'(high_water);
          tbl_wdata       = {1'b1, 3'b000, {GEN_BITS{1'b0}}};
          live_total_next = live_total + HW'(1);
          pending_next    = gha_pkg::merge_kind(pending, gha_pkg::PEND_TOPO);
          ok_next         = 1'b1;
          ridx_next       = 8'(high_water);
        end
      end
      gha_pkg::ACT_DESTROY: begin
        if (valid && (free_top < HW'(SLOTS))) begin
          tbl_we        = 1'b1;
          tbl_wdata     = {1'b0, 3'b000, gen_bump};
          stk_we        = 1'b1;
          free_top_next = free_top + HW'(1);
          if (live_total != '0) begin
            live_total_next = live_total - HW'(1);
          end
          pending_next = gha_pkg::merge_kind(pending, gha_pkg::PEND_TOPO);
          ok_next      = 1'b1;
          ridx_next    = idx_q;
          rgen_next    = 32'(gen_bump);
        end
      end
      gha_pkg::ACT_QUERY: begin
        if (valid) begin
          ok_next    = 1'b1;
          ridx_next  = idx_q;
          rgen_next  = gen_q;
          comps_next = rd_comps;
        end
      end
      gha_pkg::ACT_ADD, gha_pkg::ACT_REMOVE: begin
        if (valid && (kbit != 3'b000)) begin
          if (act_q == gha_pkg::ACT_ADD) begin
            new_comps = rd_comps | kbit;
            ok_next   = 1'b1;
          end else if ((rd_comps & kbit) != 3'b000) begin
            new_comps = rd_comps & ~kbit;
            ok_next   = 1'b1;
          end
          if (ok_next) begin
            tbl_we       = 1'b1;
            tbl_wdata    = {1'b1, new_comps, rd_gen};
            pending_next = gha_pkg::merge_kind(pending, kmerge);
            ridx_next    = idx_q;
            rgen_next    = gen_q;
            comps_next   = new_comps;
          end
        end
      end
      gha_pkg::ACT_CLEAR: begin
        pending_next = gha_pkg::PEND_NONE;
        ok_next      = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
    if (!cmd.exec) begin
      tbl_we = 1'b0;
      stk_we = 1'b0;
    end
  end

  // request capture and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q  <= action;
      idx_q  <= handle_index;
      gen_q  <= handle_generation;
      kind_q <= component_kind;
    end
    if (cmd.exec) begin
      ok                <= ok_next;
      result_index      <= ridx_next;
      result_generation <= rgen_next;
      comps             <= comps_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top   <= '0;
      high_water <= '0;
      live_total <= '0;
      pending    <= gha_pkg::PEND_NONE;
    end else if (cmd.exec) begin
      free_top   <= free_top_next;
      high_water <= high_water_next;
      live_total <= live_total_next;
      pending    <= pending_next;
    end
  end

  assign has_mesh       = comps[0];
  assign has_light      = comps[1];
  assign has_camera     = comps[2];
  assign pending_update = pending;
  assign live_count     = 9'(live_total);

endmodule

FILE: design/generational_handle_allocator.sv
// sequence: a word is captured on accept, read-modify-written in the exec state, and its
// result is strobed on done; no new word is taken while busy, as the slot table and free
// stack rams are read then written and share no forwarding path
// reset: rst clears free stack top, high-water mark, live count and pending kind at once;
// no clearing pass, slots above the high-water mark are initialised on first create
module generational_handle_allocator #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // request word, taken when start is high and busy is low
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [7:0]  handle_index,
  input  logic [31:0] handle_generation,
  input  logic [1:0]  component_kind,
  // result word, valid for the single cycle in which done is high
  output logic        done,
  output logic        ok,
  output logic [7:0]  result_index,
  output logic [31:0] result_generation,
  output logic        has_mesh,
  output logic        has_light,
  output logic        has_camera,
  output logic [1:0]  pending_update,
  output logic [8:0]  live_count
);

  // load captures the request word, exec runs the read-modify-write
  gha_pkg::cmd_t cmd;

  // sequencer: idle, then an execute state for each word
  gha_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // slot table, free stack and bookkeeping; the slot table read is launched at the accept
  // edge straight from the request port, the free stack read from its top
  gha_dp #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .action            (action),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .component_kind    (component_kind),
    .ok                (ok),
    .result_index      (result_index),
    .result_generation (result_generation),
    .has_mesh          (has_mesh),
    .has_light         (has_light),
    .has_camera        (has_camera),
    .pending_update    (pending_update),
    .live_count        (live_count)
  );

endmodule

FILE: design/gha_checker.sv
// port-level checks on the handle allocator, bound to the top level
// depends on generational_handle_allocator_defines.svh
`include "generational_handle_allocator_defines.svh"

module gha_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] pending_update,
  input logic [8:0] live_count
);

  `GHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `GHA_ASSERT_NEXT(a_busy_done, busy, done && !busy)
  `GHA_ASSERT_IMPL(a_live_on_done, !$stable(live_count), done)
  `GHA_ASSERT_IMPL(a_pend_on_done, !$stable(pending_update), done)

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .pending_update (pending_update),
  .live_count     (live_count)
);

FILE: dv/tb_top.sv
// self-checking testbench for the generational handle allocator
// depends on gha_pkg and generational_handle_allocator; predicts each result word in-line
`timescale 1ns / 1ps

module tb_top;

  // codes the package leaves out
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  localparam logic [1:0] COMP_BAD    = 2'd3;

  localparam int SLOT_COUNT  = 256;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic        ok;
    logic [7:0]  idx;
    logic [31:0] gen;
    logic        mesh;
    logic        light;
    logic        camera;
    logic [1:0]  pend;
    logic [8:0]  live;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  action = gha_pkg::ACT_CLEAR;
  logic [7:0]  handle_index = '0;
  logic [31:0] handle_generation = '0;
  logic [1:0]  component_kind = gha_pkg::COMP_MESH;

  logic        busy;
  logic        done;
  logic        ok;
  logic [7:0]  result_index;
  logic [31:0] result_generation;
  logic        has_mesh;
  logic        has_light;
  logic        has_camera;
  logic [1:0]  pending_update;
  logic [8:0]  live_count;

  generational_handle_allocator uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .handle_index(handle_index),
    .handle_generation(handle_generation),
    .component_kind(component_kind),
    .done(done),
    .ok(ok),
    .result_index(result_index),
    .result_generation(result_generation),
    .has_mesh(has_mesh),
    .has_light(has_light),
    .has_camera(has_camera),
    .pending_update(pending_update),
    .live_count(live_count)
  );

  // shadow copy of the slot map
  logic [7:0]  free_slots [SLOT_COUNT];
  int          free_depth = 0;
  int          hw_mark = 0;
  logic [31:0] gen_tab [SLOT_COUNT];
  logic        live_tab [SLOT_COUNT];
  logic [2:0]  comp_tab [SLOT_COUNT];
  int          live_total = 0;
  logic [1:0]  pend_kind = gha_pkg::PEND_NONE;

  alloc_result_t expected_words [$];
  int words_sent = 0;
  int results_seen = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void fold_pending(input logic [1:0] k);
    if (pend_kind == gha_pkg::PEND_NONE) begin
      pend_kind = k;
    end else if (pend_kind != k) begin
      pend_kind = gha_pkg::PEND_TOPO;
    end
  endfunction

  function automatic logic handle_valid(input logic [7:0] idx, input logic [31:0] gen);
    if (int'(idx) >= hw_mark) return 1'b0;
    return live_tab[idx] && gen_tab[idx] == gen;
  endfunction

  // expected result word for one request, updating the shadow slot map
  function automatic alloc_result_t predict_alloc(input logic [2:0] act,
                                                  input logic [7:0] idx,
                                                  input logic [31:0] gen,
                                                  input logic [1:0] kind);
    alloc_result_t r;
    int            s;
    logic          got;
    logic [2:0]    flag;
    logic [1:0]    comp_pend;
    r = '0;
    s = 0;
    got = 1'b0;
    case (act)
      gha_pkg::ACT_CREATE: begin
        // freed slots are reused last-in first-out before fresh ones
        if (free_depth > 0) begin
          free_depth--;
          s = int'(free_slots[free_depth]);
          got = 1'b1;
        end else if (hw_mark < SLOT_COUNT) begin
          s = hw_mark;
          hw_mark++;
          gen_tab[s] = '0;
          got = 1'b1;
        end
        if (got) begin
          live_tab[s] = 1'b1;
          comp_tab[s] = '0;
          live_total++;
          fold_pending(gha_pkg::PEND_TOPO);
          r.ok = 1'b1;
          r.idx = s[7:0];
          r.gen = gen_tab[s];
        end
      end
      gha_pkg::ACT_DESTROY: begin
        if (handle_valid(idx, gen) && free_depth < SLOT_COUNT) begin
          live_tab[idx] = 1'b0;
          comp_tab[idx] = '0;
          gen_tab[idx] = gen_tab[idx] + 32'd1;
          free_slots[free_depth] = idx;
          free_depth++;
          if (live_total > 0) live_total--;
          fold_pending(gha_pkg::PEND_TOPO);
          r.ok = 1'b1;
          r.idx = idx;
          r.gen = gen_tab[idx];
        end
      end
      gha_pkg::ACT_QUERY: begin
        if (handle_valid(idx, gen)) begin
          r.ok = 1'b1;
          r.idx = idx;
          r.gen = gen;
          {r.camera, r.light, r.mesh} = comp_tab[idx];
        end
      end
      gha_pkg::ACT_ADD, gha_pkg::ACT_REMOVE: begin
        if (kind != COMP_BAD && handle_valid(idx, gen)) begin
          flag = 3'b001 << kind;
          case (kind)
            gha_pkg::COMP_MESH:  comp_pend = gha_pkg::PEND_TOPO;
            gha_pkg::COMP_LIGHT: comp_pend = gha_pkg::PEND_LIGHT;
            default:             comp_pend = gha_pkg::PEND_CAMERA;
          endcase
          if (act == gha_pkg::ACT_ADD) begin
            comp_tab[idx] = comp_tab[idx] | flag;
            fold_pending(comp_pend);
            r.ok = 1'b1;
          end else if ((comp_tab[idx] & flag) != '0) begin
            comp_tab[idx] = comp_tab[idx] & ~flag;
            fold_pending(comp_pend);
            r.ok = 1'b1;
          end
          if (r.ok) begin
            r.idx = idx;
            r.gen = gen;
            {r.camera, r.light, r.mesh} = comp_tab[idx];
          end
        end
      end
      gha_pkg::ACT_CLEAR: begin
        pend_kind = gha_pkg::PEND_NONE;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.pend = pend_kind;
    r.live = live_total[8:0];
    return r;
  endfunction

  function automatic logic pick_live(output logic [7:0] idx);
    int base;
    int s;
    idx = '0;
    if (live_total == 0 || hw_mark == 0) return 1'b0;
    base = $urandom_range(hw_mark - 1);
    for (int i = 0; i < hw_mark; i++) begin
      s = (base + i) % hw_mark;
      if (live_tab[s]) begin
        idx = s[7:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("mismatch on result word %0d, %0s: got %0h, want %0h",
             results_seen, field, got, want);
  endtask

  // one request word; returns in the step of the edge that took it
  task automatic send_word(input logic [2:0] act, input logic [7:0] idx,
                           input logic [31:0] gen, input logic [1:0] kind);
    start <= 1'b1;
    action <= act;
    handle_index <= idx;
    handle_generation <= gen;
    component_kind <= kind;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected_words.insert(expected_words.size(), predict_alloc(act, idx, gen, kind));
    words_sent++;
  endtask

  task automatic maybe_pause(input int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // result checker: every strobed word is matched against the oldest prediction
  always @(posedge clk) begin : check_words
    alloc_result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_words.size() == 0) begin
        report_mismatch("word with nothing outstanding", '0, '0);
      end else begin
        want = expected_words.pop_front();
        if (ok !== want.ok) report_mismatch("ok", 32'(ok), 32'(want.ok));
        if (result_index !== want.idx)
          report_mismatch("result_index", 32'(result_index), 32'(want.idx));
        if (result_generation !== want.gen)
          report_mismatch("result_generation", result_generation, want.gen);
        if (has_mesh !== want.mesh)
          report_mismatch("has_mesh", 32'(has_mesh), 32'(want.mesh));
        if (has_light !== want.light)
          report_mismatch("has_light", 32'(has_light), 32'(want.light));
        if (has_camera !== want.camera)
          report_mismatch("has_camera", 32'(has_camera), 32'(want.camera));
        if (pending_update !== want.pend)
          report_mismatch("pending_update", 32'(pending_update), 32'(want.pend));
        if (live_count !== want.live)
          report_mismatch("live_count", 32'(live_count), 32'(want.live));
        results_seen++;
      end
    end
  end

  // watchdog on cycles with neither a word taken nor a result strobed
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // create, flag handling, pending-kind merging, stale handles and spare actions
  task automatic test_directed();
    send_word(gha_pkg::ACT_CREATE, 8'($urandom), $urandom, 2'($urandom));
    send_word(gha_pkg::ACT_CREATE, 8'($urandom), $urandom, 2'($urandom));
    send_word(gha_pkg::ACT_CREATE, 8'($urandom), $urandom, 2'($urandom));
    send_word(gha_pkg::ACT_QUERY, 8'd0, 32'd0, gha_pkg::COMP_MESH);
    send_word(gha_pkg::ACT_QUERY, 8'd0, 32'hFFFF_FFFF, gha_pkg::COMP_MESH);
    // index above the high-water mark
    send_word(gha_pkg::ACT_QUERY, 8'd255, 32'd0, gha_pkg::COMP_CAMERA);
    send_word(gha_pkg::ACT_ADD, 8'd0, 32'd0, gha_pkg::COMP_MESH);
    send_word(gha_pkg::ACT_ADD, 8'd0, 32'd0, gha_pkg::COMP_LIGHT);
    send_word(gha_pkg::ACT_ADD, 8'd0, 32'd0, gha_pkg::COMP_CAMERA);
    send_word(gha_pkg::ACT_ADD, 8'd0, 32'd0, gha_pkg::COMP_MESH);
    send_word(gha_pkg::ACT_ADD, 8'd0, 32'd0, COMP_BAD);
    send_word(gha_pkg::ACT_REMOVE, 8'd0, 32'd0, gha_pkg::COMP_LIGHT);
    send_word(gha_pkg::ACT_REMOVE, 8'd0, 32'd0, gha_pkg::COMP_LIGHT);
    send_word(gha_pkg::ACT_REMOVE, 8'd0, 32'd0, COMP_BAD);
    send_word(gha_pkg::ACT_CLEAR, 8'($urandom), $urandom, 2'($urandom));
    // light then camera merges to topology
    send_word(gha_pkg::ACT_ADD, 8'd1, 32'd0, gha_pkg::COMP_LIGHT);
    send_word(gha_pkg::ACT_ADD, 8'd1, 32'd0, gha_pkg::COMP_CAMERA);
    send_word(gha_pkg::ACT_CLEAR, 8'($urandom), $urandom, 2'($urandom));
    send_word(gha_pkg::ACT_ADD, 8'd2, 32'd0, gha_pkg::COMP_CAMERA);
    send_word(gha_pkg::ACT_REMOVE, 8'd2, 32'd0, gha_pkg::COMP_CAMERA);
    send_word(gha_pkg::ACT_DESTROY, 8'd1, 32'd0, gha_pkg::COMP_MESH);
    send_word(gha_pkg::ACT_QUERY, 8'd1, 32'd0, gha_pkg::COMP_MESH);
    send_word(gha_pkg::ACT_DESTROY, 8'd1, 32'd0, gha_pkg::COMP_MESH);
    send_word(gha_pkg::ACT_CREATE, 8'($urandom), $urandom, 2'($urandom));
    send_word(ACT_SPARE_A, 8'($urandom), $urandom, 2'($urandom));
    send_word(ACT_SPARE_B, 8'($urandom), $urandom, 2'($urandom));
  endtask

  // fill every slot, hit the full store, then free and retake the top slot
  task automatic test_store_full();
    while (!(free_depth == 0 && hw_mark == SLOT_COUNT)) begin
      send_word(gha_pkg::ACT_CREATE, 8'($urandom), $urandom, 2'($urandom));
      maybe_pause(22);
    end
    send_word(gha_pkg::ACT_CREATE, 8'($urandom), $urandom, 2'($urandom));
    send_word(gha_pkg::ACT_QUERY, 8'd255, gen_tab[255], gha_pkg::COMP_MESH);
    send_word(gha_pkg::ACT_ADD, 8'd255, gen_tab[255], gha_pkg::COMP_CAMERA);
    send_word(gha_pkg::ACT_DESTROY, 8'd255, gen_tab[255], gha_pkg::COMP_LIGHT);
    send_word(gha_pkg::ACT_CREATE, 8'($urandom), $urandom, 2'($urandom));
    send_word(gha_pkg::ACT_CREATE, 8'($urandom), $urandom, 2'($urandom));
  endtask

  // mostly well-formed traffic on live handles, the population ebbing and flowing
  task automatic test_random_traffic(input int n_words, input int pause_pct);
    int          roll;
    int          c_pct;
    int          d_pct;
    logic        filling;
    logic [7:0]  idx;
    logic [31:0] g;
    logic [1:0]  kind;
    logic [2:0]  act;
    filling = 1'b1;
    for (int n = 0; n < n_words; n++) begin
      if (n % 64 == 0) filling = 1'($urandom_range(1));
      c_pct = filling ? 30 : 8;
      d_pct = filling ? 8 : 30;
      roll = $urandom_range(99);
      kind = ($urandom_range(7) == 0) ? COMP_BAD : 2'($urandom_range(2));
      if (roll < c_pct || (roll < 90 && !pick_live(idx))) begin
        send_word(gha_pkg::ACT_CREATE, 8'($urandom), $urandom, 2'($urandom));
      end else if (roll < c_pct + d_pct) begin
        send_word(gha_pkg::ACT_DESTROY, idx, gen_tab[idx], 2'($urandom));
      end else if (roll < 50) begin
        send_word(gha_pkg::ACT_QUERY, idx, gen_tab[idx], 2'($urandom));
      end else if (roll < 70) begin
        send_word(gha_pkg::ACT_ADD, idx, gen_tab[idx], kind);
      end else if (roll < 86) begin
        send_word(gha_pkg::ACT_REMOVE, idx, gen_tab[idx], kind);
      end else if (roll < 90) begin
        send_word(gha_pkg::ACT_CLEAR, 8'($urandom), $urandom, 2'($urandom));
      end else if (hw_mark > 0 && $urandom_range(1)) begin
        // stale handle: previous generation of a freed slot or one flipped bit
        idx = 8'($urandom_range(hw_mark - 1));
        g = live_tab[idx] ? gen_tab[idx] ^ (32'd1 << $urandom_range(31))
                          : gen_tab[idx] - 32'd1;
        act = 3'($urandom_range(gha_pkg::ACT_DESTROY, gha_pkg::ACT_REMOVE));
        send_word(act, idx, g, kind);
      end else begin
        send_word(3'($urandom), 8'($urandom), $urandom, 2'($urandom));
      end
      maybe_pause(pause_pct);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    wait_results_drained();
    test_store_full();
    // hold off until the store-full results are all back
    wait_results_drained();
    test_random_traffic(255, 0);
    test_random_traffic(255, 50);
    wait_results_drained();
    test_random_traffic(255, 0);
    test_random_traffic(255, 22);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch("outstanding at end", 32'(expected_words.size()), 32'd0);

    $display("covered %0d request words and %0d result words: directed cases, full store,",
             words_sent, results_seen);
    $display("random traffic with sender pauses at 0, 50 and 22 percent");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
